FILE: sv/taylor_series_sine_assert.svh
// assertion macros used by the checker file
`ifndef TAYLOR_SERIES_SINE_ASSERT_SVH
`define TAYLOR_SERIES_SINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst is high
`define TSS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tss check failed");

// next-cycle implication, sampled on clk, off while rst is high
`define TSS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tss check failed");

`endif

FILE: sv/tss_pkg.sv
`default_nettype none

package tss_pkg;

  localparam int DEF_MAX_TERMS = 16;
  localparam int DEF_FRAC_BITS = 28;

  localparam int ANGLE_W   = 32;
  localparam int EPS_W     = 29;
  localparam int COUNT_W   = 5;
  localparam int OUT_CNT_W = 5;
  localparam int CFG_IDX_W = 2;
  // wide enough for any term count up to the largest cap
  localparam int CNT_W     = 6;

  // term magnitudes stay at or below 2^61, the running sum within +-2^61
  localparam int TERM_W = 62;
  localparam int HALF_W = TERM_W / 2;
  localparam int SUM_W  = TERM_W + 1;
  localparam logic [TERM_W-1:0] INNER_CAP = {1'b1, {(TERM_W-1){1'b0}}};

  localparam logic [COUNT_W-1:0] RST_TERM_COUNT = 5'd8;
  localparam logic [EPS_W-1:0]   RST_EPSILON    = 29'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STOP_MODE  = 2'd0,
    CFG_TERM_COUNT = 2'd1,
    CFG_EPSILON    = 2'd2
  } tss_cfg_idx_t;

  typedef struct packed {
    logic             eps_mode;
    logic [EPS_W-1:0] eps;
  } tss_ctl_t;

  typedef struct packed {
    logic done;
    logic cap;
    logic tneg;
  } tss_flags_t;

  // decides whether the series stops after the term just produced
  function automatic tss_flags_t next_flags(
    input tss_ctl_t          ctl,
    input logic [TERM_W-1:0] tmag,
    input logic [CNT_W-1:0]  used,
    input logic [CNT_W-1:0]  limit,
    input logic [CNT_W-1:0]  max_terms,
    input logic              tneg
  );
    tss_flags_t f;
    f.tneg = tneg;
    f.done = 1'b0;
    f.cap  = 1'b0;
    if (ctl.eps_mode) begin
      if (tmag <= {{(TERM_W-EPS_W){1'b0}}, ctl.eps}) begin
        f.done = 1'b1;
      end else if (used >= max_terms) begin
        f.done = 1'b1;
        f.cap  = 1'b1;
      end
    end else if (used >= limit) begin
      f.done = 1'b1;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

FILE: sv/taylor_series_sine.sv
// Sine of a signed Q3.28 angle (FRAC_BITS fraction bits) by its Maclaurin series, saturated
// to 32 bits, with the number of terms summed and a flag when the epsilon rule ran into
// MAX_TERMS. Configuration: index 0 stop_mode (0 fixed count, 1 epsilon rule), index 1
// term_count, index 2 epsilon_threshold; other indexes are ignored and cfg_ready is always
// high. The datapath is a front stage followed by a row of MAX_TERMS-1 term cells, one per
// later term, each with seven register stages (two split multiplies of the term by x^2 and
// by the cell's reciprocal, rounding, and the sum update); a cell whose series has already
// stopped passes the item along unchanged. An angle request is accepted every clock unless
// a result is waiting in the last cell while the output register is still full. Results
// come out in the order their requests were accepted, each passing through every cell
// under either stopping rule.
`default_nettype none

module taylor_series_sine #(
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS,
  parameter int FRAC_BITS = tss_pkg::DEF_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tss_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tss_pkg::EPS_W-1:0]            cfg_data,
  input  logic                                 angle_valid,
  output logic                                 angle_ready,
  input  logic signed [tss_pkg::ANGLE_W-1:0]   angle,
  output logic                                 sine_valid,
  input  logic                                 sine_ready,
  output logic signed [tss_pkg::ANGLE_W-1:0]   sine_value,
  output logic [tss_pkg::OUT_CNT_W-1:0]        terms_used,
  output logic                                 cap_reached
);

  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int X2W = 63 - FRAC_BITS;
  localparam int NC  = MAX_TERMS - 1;
  localparam int NW  = tss_pkg::CNT_W;
  localparam int TW  = tss_pkg::TERM_W;
  localparam int SW  = tss_pkg::SUM_W;
  localparam int AW  = tss_pkg::ANGLE_W;
  localparam int OW  = tss_pkg::OUT_CNT_W;

  logic                          stop_mode;
  logic [tss_pkg::COUNT_W-1:0]   term_count;
  logic [tss_pkg::EPS_W-1:0]     epsilon_threshold;

  logic [NW-1:0]                 lim_wide;
  logic [CW-1:0]                 limit;
  tss_pkg::tss_ctl_t             ctl;
  logic                          adv;

  logic                          ch_valid [NC+1];
  tss_pkg::tss_flags_t           ch_flags [NC+1];
  logic [TW-1:0]                 ch_tmag  [NC+1];
  logic signed [SW-1:0]          ch_sum   [NC+1];
  logic [CW-1:0]                 ch_used  [NC+1];
  logic [X2W-1:0]                ch_x2    [NC+1];

  logic signed [SW-1:0]          fin_sum;
  logic signed [AW-1:0]          sat_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_mode         <= 1'b0;
      term_count        <= tss_pkg::RST_TERM_COUNT;
      epsilon_threshold <= tss_pkg::RST_EPSILON;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        tss_pkg::CFG_STOP_MODE:  stop_mode         <= cfg_data[0];
        tss_pkg::CFG_TERM_COUNT: term_count        <= cfg_data[tss_pkg::COUNT_W-1:0];
        tss_pkg::CFG_EPSILON:    epsilon_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // fixed-count limit: zero acts as one, anything past the cap acts as the cap
  always_comb begin
    if (term_count == '0) begin
      lim_wide = NW'(1);
    end else if (NW'(term_count) > NW'(MAX_TERMS)) begin
      lim_wide = NW'(MAX_TERMS);
    end else begin
      lim_wide = NW'(term_count);
    end
    limit        = CW'(lim_wide);
    ctl.eps_mode = stop_mode;
    ctl.eps      = epsilon_threshold;
  end

  // the pipe moves unless a finished result is blocked behind a full output register
  assign adv         = !ch_valid[NC] || !sine_valid || sine_ready;
  assign angle_ready = adv;

  tss_front #(
    .FRAC_BITS (FRAC_BITS),
    .MAX_TERMS (MAX_TERMS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .angle_valid (angle_valid),
    .angle       (angle),
    .ctl         (ctl),
    .limit       (limit),
    .dn_valid    (ch_valid[0]),
    .dn_flags    (ch_flags[0]),
    .dn_tmag     (ch_tmag[0]),
    .dn_sum      (ch_sum[0]),
    .dn_used     (ch_used[0]),
    .dn_x2       (ch_x2[0])
  );

  for (genvar k = 0; k < NC; k++) begin : g_cell
    tss_cell #(
      .FRAC_BITS (FRAC_BITS),
      .MAX_TERMS (MAX_TERMS),
      .INDEX     (k)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .ctl      (ctl),
      .limit    (limit),
      .up_valid (ch_valid[k]),
      .up_flags (ch_flags[k]),
      .up_tmag  (ch_tmag[k]),
      .up_sum   (ch_sum[k]),
      .up_used  (ch_used[k]),
      .up_x2    (ch_x2[k]),
      .dn_valid (ch_valid[k+1]),
      .dn_flags (ch_flags[k+1]),
      .dn_tmag  (ch_tmag[k+1]),
      .dn_sum   (ch_sum[k+1]),
      .dn_used  (ch_used[k+1]),
      .dn_x2    (ch_x2[k+1])
    );
  end

  // saturate: the sum fits the output when all bits above bit 30 agree
  always_comb begin
    fin_sum = ch_sum[NC];
    if (!fin_sum[SW-1] && (|fin_sum[SW-2:AW-1])) begin
      sat_value = {1'b0, {(AW-1){1'b1}}};
    end else if (fin_sum[SW-1] && !(&fin_sum[SW-2:AW-1])) begin
      sat_value = {1'b1, {(AW-1){1'b0}}};
    end else begin
      sat_value = fin_sum[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sine_valid <= 1'b0;
    end else begin
      if (sine_valid && sine_ready) begin
        sine_valid <= 1'b0;
      end
      if (adv && ch_valid[NC]) begin
        sine_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && ch_valid[NC]) begin
      sine_value  <= sat_value;
      terms_used  <= OW'(ch_used[NC]);
      cap_reached <= ch_flags[NC].cap;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tss_front.sv
`default_nettype none

module tss_front #(
  parameter int FRAC_BITS = tss_pkg::DEF_FRAC_BITS,
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  logic                                angle_valid,
  input  logic [tss_pkg::ANGLE_W-1:0]         angle,
  input  tss_pkg::tss_ctl_t                   ctl,
  input  logic [$clog2(MAX_TERMS+1)-1:0]      limit,
  output logic                                dn_valid,
  output tss_pkg::tss_flags_t                 dn_flags,
  output logic [tss_pkg::TERM_W-1:0]          dn_tmag,
  output logic signed [tss_pkg::SUM_W-1:0]    dn_sum,
  output logic [$clog2(MAX_TERMS+1)-1:0]      dn_used,
  output logic [63-FRAC_BITS-1:0]             dn_x2
);

  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int X2W = 63 - FRAC_BITS;
  localparam int AW  = tss_pkg::ANGLE_W;
  localparam int NW  = tss_pkg::CNT_W;
  localparam int TW  = tss_pkg::TERM_W;
  localparam int SW  = tss_pkg::SUM_W;

  logic                 a_valid;
  logic [AW-1:0]        ang;
  logic                 a_neg;
  logic [AW-1:0]        a_mag;

  logic                 b_valid;
  logic                 b_neg;
  logic [AW-1:0]        b_mag;
  logic [2*AW-1:0]      b_sq;

  logic [2*AW-1:0]      sq_round;
  logic [X2W-1:0]       x2_next;
  logic signed [SW-1:0] mag_s;
  logic signed [SW-1:0] sum_next;
  tss_pkg::tss_flags_t  flags_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      b_valid  <= 1'b0;
      dn_valid <= 1'b0;
    end else if (adv) begin
      a_valid  <= angle_valid;
      b_valid  <= a_valid;
      dn_valid <= b_valid;
    end
  end

  // magnitude of the most negative angle is 2^31, still fits unsigned
  always_comb begin
    a_neg = ang[AW-1];
    a_mag = a_neg ? (~ang + AW'(1)) : ang;
  end

  always_comb begin
    sq_round   = b_sq + ((2*AW)'(1) << (FRAC_BITS - 1));
    x2_next    = X2W'(sq_round >> FRAC_BITS);
    mag_s      = $signed({{(SW-AW){1'b0}}, b_mag});
    sum_next   = b_neg ? -mag_s : mag_s;
    flags_next = tss_pkg::next_flags(ctl, {{(TW-AW){1'b0}}, b_mag}, NW'(1), NW'(limit),
                                     NW'(MAX_TERMS), b_neg);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang      <= angle;
      b_neg    <= a_neg;
      b_mag    <= a_mag;
      b_sq     <= (2*AW)'(a_mag) * (2*AW)'(a_mag);
      dn_flags <= flags_next;
      dn_tmag  <= {{(TW-AW){1'b0}}, b_mag};
      dn_sum   <= sum_next;
      dn_used  <= CW'(1);
      dn_x2    <= x2_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/tss_cell.sv
`default_nettype none

module tss_cell #(
  parameter int FRAC_BITS = tss_pkg::DEF_FRAC_BITS,
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS,
  parameter int INDEX     = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                adv,
  input  tss_pkg::tss_ctl_t                   ctl,
  input  logic [$clog2(MAX_TERMS+1)-1:0]      limit,
  input  logic                                up_valid,
  input  tss_pkg::tss_flags_t                 up_flags,
  input  logic [tss_pkg::TERM_W-1:0]          up_tmag,
  input  logic signed [tss_pkg::SUM_W-1:0]    up_sum,
  input  logic [$clog2(MAX_TERMS+1)-1:0]      up_used,
  input  logic [63-FRAC_BITS-1:0]             up_x2,
  output logic                                dn_valid,
  output tss_pkg::tss_flags_t                 dn_flags,
  output logic [tss_pkg::TERM_W-1:0]          dn_tmag,
  output logic signed [tss_pkg::SUM_W-1:0]    dn_sum,
  output logic [$clog2(MAX_TERMS+1)-1:0]      dn_used,
  output logic [63-FRAC_BITS-1:0]             dn_x2
);

  localparam int CW  = $clog2(MAX_TERMS + 1);
  localparam int X2W = 63 - FRAC_BITS;
  localparam int TW  = tss_pkg::TERM_W;
  localparam int HW  = tss_pkg::HALF_W;
  localparam int SW  = tss_pkg::SUM_W;
  localparam int NW  = tss_pkg::CNT_W;
  localparam int NS  = 6;
  localparam int PW  = HW + X2W;
  localparam int FW  = TW + X2W + 1;
  localparam int QW  = HW + 32;
  localparam int RW  = TW + 32 + 1;

  // reciprocal of (2i+2)(2i+3) as unsigned Q0.32, rounded to nearest
  localparam int D = (2 * INDEX + 2) * (2 * INDEX + 3);
  localparam logic [63:0] RECIP_FULL = ((64'd1 << 32) + 64'(D / 2)) / 64'(D);
  localparam logic [31:0] RECIP = RECIP_FULL[31:0];

  localparam logic signed [SW:0] SCAP = $signed({2'b00, tss_pkg::INNER_CAP});

  logic [NS-1:0]        vld;
  tss_pkg::tss_flags_t  flg  [NS];
  logic signed [SW-1:0] sum  [NS];
  logic [CW-1:0]        used [NS];
  logic [X2W-1:0]       x2   [NS];

  logic [PW-1:0]        pl1;
  logic [HW-1:0]        thi1;
  logic [PW-1:0]        ph2;
  logic [PW-1:0]        pl2;
  logic [TW-1:0]        m3;
  logic [QW-1:0]        ql4;
  logic [HW-1:0]        mhi4;
  logic [QW-1:0]        qh5;
  logic [QW-1:0]        ql5;
  logic [TW-1:0]        t6;

  logic [FW-1:0]        full2;
  logic [FW-1:0]        q2;
  logic [TW-1:0]        m3_next;
  logic [RW-1:0]        full5;
  logic [TW-1:0]        t6_next;

  logic                 new_neg;
  logic signed [SW:0]   sum_ext;
  logic signed [SW:0]   t_ext;
  logic signed [SW:0]   acc;
  logic signed [SW-1:0] sum_new;
  logic [CW-1:0]        used_new;
  tss_pkg::tss_flags_t  flags_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      dn_valid <= 1'b0;
    end else if (adv) begin
      vld      <= {vld[NS-2:0], up_valid};
      dn_valid <= vld[NS-1];
    end
  end

  // term * x^2, rounded at the fraction point and clamped
  always_comb begin
    full2   = (FW'(ph2) << HW) + FW'(pl2) + (FW'(1) << (FRAC_BITS - 1));
    q2      = full2 >> FRAC_BITS;
    m3_next = (q2 > FW'(tss_pkg::INNER_CAP)) ? tss_pkg::INNER_CAP : q2[TW-1:0];
  end

  // times the reciprocal, rounded at bit 32; stays below the clamp
  always_comb begin
    full5   = (RW'(qh5) << HW) + RW'(ql5) + (RW'(1) << 31);
    t6_next = TW'(full5 >> 32);
  end

  always_comb begin
    new_neg   = ~flg[NS-1].tneg;
    sum_ext   = {sum[NS-1][SW-1], sum[NS-1]};
    t_ext     = $signed({2'b00, t6});
    acc       = new_neg ? (sum_ext - t_ext) : (sum_ext + t_ext);
    if (acc > SCAP) begin
      sum_new = SW'(SCAP);
    end else if (acc < -SCAP) begin
      sum_new = SW'(-SCAP);
    end else begin
      sum_new = acc[SW-1:0];
    end
    used_new  = used[NS-1] + CW'(1);
    flags_new = tss_pkg::next_flags(ctl, t6, NW'(used_new), NW'(limit), NW'(MAX_TERMS),
                                    new_neg);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      flg[0]  <= up_flags;
      sum[0]  <= up_sum;
      used[0] <= up_used;
      x2[0]   <= up_x2;
      for (int k = 1; k < NS; k++) begin
        flg[k]  <= flg[k-1];
        sum[k]  <= sum[k-1];
        used[k] <= used[k-1];
        x2[k]   <= x2[k-1];
      end

      pl1  <= PW'(up_tmag[HW-1:0]) * PW'(up_x2);
      thi1 <= up_tmag[TW-1:HW];
      ph2  <= PW'(thi1) * PW'(x2[0]);
      pl2  <= pl1;
      m3   <= m3_next;
      ql4  <= QW'(m3[HW-1:0]) * QW'(RECIP);
      mhi4 <= m3[TW-1:HW];
      qh5  <= QW'(mhi4) * QW'(RECIP);
      ql5  <= ql4;
      t6   <= t6_next;

      dn_tmag <= t6;
      dn_x2   <= x2[NS-1];
      // a finished series rides through untouched
      if (flg[NS-1].done) begin
        dn_flags <= flg[NS-1];
        dn_sum   <= sum[NS-1];
        dn_used  <= used[NS-1];
      end else begin
        dn_flags <= flags_new;
        dn_sum   <= sum_new;
        dn_used  <= used_new;
      end
    end
  end

endmodule

`default_nettype wire

FILE: sv/tss_check.sv
`default_nettype none
`include "taylor_series_sine_assert.svh"

module tss_check #(
  parameter int MAX_TERMS = tss_pkg::DEF_MAX_TERMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sine_valid,
  input  logic                                sine_ready,
  input  logic signed [tss_pkg::ANGLE_W-1:0]  sine_value,
  input  logic [tss_pkg::OUT_CNT_W-1:0]       terms_used,
  input  logic                                cap_reached
);

  localparam int NW = tss_pkg::CNT_W;
  localparam int OW = tss_pkg::OUT_CNT_W;

  // at least one term, never more than the cap (a count of 32 wraps to zero)
  `TSS_ASSERT_SAME(a_count_range, sine_valid && MAX_TERMS < 32, terms_used != '0 && NW'(terms_used) <= NW'(MAX_TERMS))

  // the cap flag only comes with a full set of terms
  `TSS_ASSERT_SAME(a_cap_at_limit, sine_valid && cap_reached, terms_used == OW'(MAX_TERMS))

  `TSS_ASSERT_NEXT(a_hold_stalled, sine_valid && !sine_ready, sine_valid && $stable(sine_value) && $stable(terms_used) && $stable(cap_reached))

  // nothing comes out right after reset
  `TSS_ASSERT_SAME(a_empty_after_reset, $past(rst), !sine_valid)

endmodule

bind taylor_series_sine tss_check #(
  .MAX_TERMS (MAX_TERMS)
) u_tss_check (
  .clk         (clk),
  .rst         (rst),
  .sine_valid  (sine_valid),
  .sine_ready  (sine_ready),
  .sine_value  (sine_value),
  .terms_used  (terms_used),
  .cap_reached (cap_reached)
);

`default_nettype wire

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int TERM_MAX  = tss_pkg::DEF_MAX_TERMS;
  localparam int FRAC      = tss_pkg::DEF_FRAC_BITS;
  localparam int LATENCY   = 4 + 7 * (TERM_MAX - 1);
  localparam int CYCLE_CAP = 400000;
  localparam logic [tss_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam longint TERM_LIMIT = 64'h2000_0000_0000_0000;

  typedef struct packed {
    logic signed [tss_pkg::ANGLE_W-1:0] sine;
    logic [tss_pkg::OUT_CNT_W-1:0]      terms;
    logic                               cap;
  } sine_result_t;

  logic                               clk;
  logic                               rst;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [tss_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [tss_pkg::EPS_W-1:0]          cfg_data;
  logic                               angle_valid;
  logic                               angle_ready;
  logic signed [tss_pkg::ANGLE_W-1:0] angle;
  logic                               sine_valid;
  logic                               sine_ready;
  logic signed [tss_pkg::ANGLE_W-1:0] sine_value;
  logic [tss_pkg::OUT_CNT_W-1:0]      terms_used;
  logic                               cap_reached;

  // shadow copy of the configuration registers
  logic                          mode_q;
  logic [tss_pkg::COUNT_W-1:0]   count_q;
  logic [tss_pkg::EPS_W-1:0]     eps_q;

  sine_result_t expected_sines[$];
  sine_result_t want;
  int           mismatches;
  int           cycles;
  int           send_idle_pct;
  int           recv_idle_pct;

  taylor_series_sine dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .angle_valid (angle_valid),
    .angle_ready (angle_ready),
    .angle       (angle),
    .sine_valid  (sine_valid),
    .sine_ready  (sine_ready),
    .sine_value  (sine_value),
    .terms_used  (terms_used),
    .cap_reached (cap_reached)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // (a * b) >> sh rounded half up, clamped to 2^61
  function automatic logic [63:0] scaled_product(input logic [63:0] a, input logic [63:0] b,
                                                 input int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = (p + (128'd1 << (sh - 1))) >> sh;
    if (p > TERM_LIMIT) return TERM_LIMIT;
    return p[63:0];
  endfunction

  function automatic sine_result_t sine_series(input logic [tss_pkg::ANGLE_W-1:0] a);
    sine_result_t r;
    logic         tneg;
    logic         done;
    logic         cap;
    logic [31:0]  neg_a;
    logic [63:0]  mag;
    logic [63:0]  tmag;
    logic [63:0]  x2;
    logic [63:0]  d;
    logic [63:0]  recip;
    longint       sum;
    int           used;
    int           limit;
    int           i;
    neg_a = -a;
    tneg  = a[31];
    mag   = a[31] ? {32'd0, neg_a} : {32'd0, a};
    x2    = scaled_product(mag, mag, FRAC);
    tmag  = mag;
    sum   = tneg ? -longint'(mag) : longint'(mag);
    used  = 1;
    i     = 0;
    cap   = 1'b0;
    done  = 1'b0;
    limit = int'(count_q);
    if (limit < 1) limit = 1;
    if (limit > TERM_MAX) limit = TERM_MAX;
    while (!done) begin
      if (mode_q) begin
        if (tmag <= {35'd0, eps_q}) begin
          done = 1'b1;
        end else if (used >= TERM_MAX) begin
          done = 1'b1;
          cap  = 1'b1;
        end
      end else if (used >= limit) begin
        done = 1'b1;
      end
      if (!done) begin
        d     = 64'((2 * i + 2) * (2 * i + 3));
        recip = ((64'd1 << 32) + d / 2) / d;
        tmag  = scaled_product(scaled_product(tmag, x2, FRAC), recip, 32);
        tneg  = ~tneg;
        sum   = sum + (tneg ? -longint'(tmag) : longint'(tmag));
        if (sum > TERM_LIMIT) sum = TERM_LIMIT;
        if (sum < -TERM_LIMIT) sum = -TERM_LIMIT;
        i++;
        used++;
      end
    end
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    r.sine  = sum[31:0];
    r.terms = used[tss_pkg::OUT_CNT_W-1:0];
    r.cap   = cap;
    return r;
  endfunction

  // result side: random stalls and in-order compare
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
    sine_ready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && sine_valid && sine_ready) begin
      if (expected_sines.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: sine %0d terms %0d cap %0d",
                   sine_value, terms_used, cap_reached);
      end else begin
        want = expected_sines.pop_front();
        if (sine_value !== want.sine || terms_used !== want.terms ||
            cap_reached !== want.cap) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: sine %0d/%0d terms %0d/%0d cap %0d/%0d (expected/actual)",
                     want.sine, sine_value, want.terms, terms_used, want.cap, cap_reached);
        end
      end
    end
  end

  // valid stays high into the next request when there is no gap
  task automatic send_angle(input logic [tss_pkg::ANGLE_W-1:0] a);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      angle_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    angle       <= a;
    angle_valid <= 1'b1;
    @(posedge clk);
    while (!angle_ready) @(posedge clk);
    expected_sines.push_back(sine_series(a));
  endtask

  task automatic wait_results_drained();
    angle_valid <= 1'b0;
    while (expected_sines.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [tss_pkg::EPS_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      tss_pkg::CFG_STOP_MODE:  mode_q  = data[0];
      tss_pkg::CFG_TERM_COUNT: count_q = data[tss_pkg::COUNT_W-1:0];
      tss_pkg::CFG_EPSILON:    eps_q   = data;
      default: ;
    endcase
  endtask

  // upper bits of the narrow registers carry junk the block must drop
  task automatic set_config(input logic mode, input logic [tss_pkg::COUNT_W-1:0] count,
                            input logic [tss_pkg::EPS_W-1:0] eps);
    wait_results_drained();
    write_reg(tss_pkg::CFG_STOP_MODE, {28'($urandom), mode});
    write_reg(tss_pkg::CFG_TERM_COUNT, {24'($urandom), count});
    write_reg(tss_pkg::CFG_EPSILON, eps);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [tss_pkg::ANGLE_W-1:0] pick_angle();
    logic [tss_pkg::ANGLE_W-1:0] a;
    case ($urandom_range(9))
      0: a = $urandom;
      1: begin
        case ($urandom_range(4))
          0: a = 32'h7FFF_FFFF;
          1: a = 32'h8000_0000;
          2: a = 32'd0;
          3: a = 32'd1;
          default: a = 32'hFFFF_FFFF;
        endcase
      end
      2, 3: a = $urandom_range(0, 32'h6487_ED51);
      default: a = $urandom_range(0, 32'h3243_F6A9);
    endcase
    if ($urandom_range(1) && a != 32'h8000_0000) a = -a;
    return a;
  endfunction

  task automatic test_default_config();
    send_angle(32'd0);
    send_angle(32'd1);
    send_angle(32'hFFFF_FFFF);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'h8000_0000);
    send_angle(32'h1921_FB54);
    send_angle(-32'h1921_FB54);
  endtask

  task automatic test_fixed_count_limits();
    // zero acts as one, anything past the cap acts as the cap
    set_config(1'b0, 5'd0, 29'd0);
    send_angle(32'h7FFF_FFFF);
    set_config(1'b0, 5'd1, 29'd0);
    send_angle(32'h8000_0000);
    set_config(1'b0, 5'd16, 29'h1FFF_FFFF);
    send_angle(32'h3243_F6A9);
    set_config(1'b0, 5'd17, 29'd4096);
    send_angle(32'h7FFF_FFFF);
    set_config(1'b0, 5'd31, 29'd4096);
    send_angle(32'h8000_0000);
  endtask

  task automatic test_epsilon_stop();
    set_config(1'b1, 5'd1, 29'd0);
    send_angle(32'h7FFF_FFFF);
    send_angle(32'd0);
    send_angle(32'h3243_F6A9);
    set_config(1'b1, 5'd31, 29'h1000_0000);
    send_angle(32'h0100_0000);
    send_angle(32'h8000_0000);
    set_config(1'b1, 5'd8, 29'h1FFF_FFFF);
    send_angle(32'h7FFF_FFFF);
  endtask

  task automatic test_unused_cfg_index();
    set_config(1'b0, 5'd4, 29'd4096);
    write_reg(CFG_UNUSED, 29'h1FFF_FFFF);
    write_reg(CFG_UNUSED, 29'd0);
    cfg_valid <= 1'b0;
    send_angle(32'h1921_FB54);
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    logic                          mode;
    logic [tss_pkg::COUNT_W-1:0]   count;
    logic [tss_pkg::EPS_W-1:0]     eps;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int n = 0; n < n_items; n++) begin
      if (n % 75 == 0) begin
        mode  = 1'($urandom_range(1));
        count = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(1, 16));
        case ($urandom_range(3))
          0: eps = 29'($urandom_range(0, 255));
          1: eps = 29'($urandom_range(0, 65535));
          2: eps = 29'($urandom_range(0, 32'h1000_0000));
          default: eps = 29'($urandom);
        endcase
        set_config(mode, count, eps);
      end
      send_angle(pick_angle());
    end
  endtask

  initial begin
    rst         <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_index   <= tss_pkg::CFG_STOP_MODE;
    cfg_data    <= '0;
    angle_valid <= 1'b0;
    angle       <= '0;
    sine_ready  <= 1'b0;
    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 32;
    recv_idle_pct = 75;
    mode_q  = 1'b0;
    count_q = tss_pkg::RST_TERM_COUNT;
    eps_q   = tss_pkg::RST_EPSILON;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_config();
    test_fixed_count_limits();
    test_epsilon_stop();
    test_unused_cfg_index();
    test_random_traffic(32, 75, 450);
    test_random_traffic(75, 32, 450);
    test_random_traffic(0, 0, 450);

    wait_results_drained();
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/tss_pkg.sv
sv/tss_front.sv
sv/tss_cell.sv
sv/taylor_series_sine.sv
sv/tss_check.sv
tb/testbench.sv
